// ===== rtl/otbuf_pkg.sv =====
// Shared types and codes of the overwriting event trace buffer.
package otbuf_pkg;

    localparam logic [1:0] ACTION_LOG   = 2'd0;
    localparam logic [1:0] ACTION_READ  = 2'd1;
    localparam logic [1:0] ACTION_CLEAR = 2'd2;

    // Widest ring index and count that the depth range allows (256 entries).
    localparam int IDX_W     = 8;
    localparam int CNT_MAX_W = 9;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_READ,
        CMD_REPORT
    } cmd_op_t;

    typedef struct packed {
        logic [31:0]        time_ms;
        logic [15:0]        code;
        logic [15:0]        source;
        logic signed [31:0] status;
        logic [31:0]        first_arg;
        logic [31:0]        second_arg;
    } record_t;

    typedef struct packed {
        cmd_op_t              op;
        logic                 bad;
        logic [IDX_W-1:0]     addr;
        record_t              rec;
        logic [CNT_MAX_W-1:0] count;
        logic [31:0]          ovw;
    } cmd_t;

endpackage

// ===== rtl/otbuf_front.sv =====
// Front end: accepts requests, keeps ring position and counters, builds commands.
module otbuf_front #(
    parameter int RING_DEPTH = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic [1:0]              action,
    input  otbuf_pkg::record_t      rec_in,
    input  logic [7:0]              age_index,
    input  logic [15:0]             boot_code,
    output otbuf_pkg::cmd_t         cmd
);

    localparam int PW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);

    logic [PW-1:0] pos_reg, pos_next;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   ovw_reg, ovw_next;

    logic [PW-1:0] base_pos;
    logic [CW-1:0] base_count;
    logic [31:0]   base_ovw;
    logic          full;
    logic          is_clear;
    logic          is_log;
    logic [PW:0]   back_sum;
    logic [PW-1:0] rd_addr;
    logic          rd_bad;

    assign is_clear = (action == otbuf_pkg::ACTION_CLEAR);
    assign is_log   = (action == otbuf_pkg::ACTION_LOG);

    // A clear restarts the ring before its boot record goes in.
    assign base_pos   = is_clear ? '0 : pos_reg;
    assign base_count = is_clear ? '0 : count_reg;
    assign base_ovw   = is_clear ? '0 : ovw_reg;
    assign full       = (base_count == CW'(RING_DEPTH));

    // Newest record sits one behind the write position; step back by the age.
    assign rd_bad   = ({1'b0, age_index} >= 9'(count_reg));
    assign back_sum = (PW+1)'(pos_reg) + (PW+1)'(RING_DEPTH - 1) - (PW+1)'(age_index);
    assign rd_addr  = (back_sum >= (PW+1)'(RING_DEPTH))
                      ? PW'(back_sum - (PW+1)'(RING_DEPTH)) : PW'(back_sum);

    always_comb
    begin
        pos_next   = pos_reg;
        count_next = count_reg;
        ovw_next   = ovw_reg;
        cmd        = '0;
        cmd.op     = otbuf_pkg::CMD_REPORT;
        if (is_log || is_clear)
        begin
            pos_next = (base_pos == PW'(RING_DEPTH - 1)) ? '0 : base_pos + PW'(1);
            if (full)
            begin
                count_next = base_count;
                ovw_next   = base_ovw + 32'd1;
            end
            else
            begin
                count_next = base_count + CW'(1);
                ovw_next   = base_ovw;
            end
        end
        unique case (action)
            otbuf_pkg::ACTION_LOG:
            begin
                cmd.op   = otbuf_pkg::CMD_WRITE;
                cmd.addr = otbuf_pkg::IDX_W'(base_pos);
                cmd.rec  = rec_in;
            end
            otbuf_pkg::ACTION_CLEAR:
            begin
                cmd.op          = otbuf_pkg::CMD_WRITE;
                cmd.addr        = otbuf_pkg::IDX_W'(base_pos);
                cmd.rec.time_ms = rec_in.time_ms;
                cmd.rec.code    = boot_code;
            end
            otbuf_pkg::ACTION_READ:
            begin
                cmd.op   = otbuf_pkg::CMD_READ;
                cmd.bad  = rd_bad;
                cmd.addr = otbuf_pkg::IDX_W'(rd_addr);
            end
            default:
            begin
                cmd.op = otbuf_pkg::CMD_REPORT;
            end
        endcase
        cmd.count = otbuf_pkg::CNT_MAX_W'(count_next);
        cmd.ovw   = ovw_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            count_reg <= '0;
            ovw_reg   <= '0;
        end
        else if (accept)
        begin
            pos_reg   <= pos_next;
            count_reg <= count_next;
            ovw_reg   <= ovw_next;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(RING_DEPTH))
        else $error("stored count beyond ring depth");

    a_ovw_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_log && count_reg != CW'(RING_DEPTH)) |=> $stable(ovw_reg))
        else $error("overwrite counter moved while ring not full");
`endif

endmodule

// ===== rtl/otbuf_queue.sv =====
// Two-entry command queue between the front end and the ring back end.
module otbuf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  otbuf_pkg::cmd_t push_cmd,
    input  logic            pop,
    output otbuf_pkg::cmd_t head,
    output logic            full,
    output logic            empty
);

    otbuf_pkg::cmd_t slot_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      fill_reg;

    assign full  = (fill_reg == 2'd2);
    assign empty = (fill_reg == 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/otbuf_back.sv =====
// Back end: record memory access and registered result.
module otbuf_back #(
    parameter int RING_DEPTH = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  otbuf_pkg::cmd_t        head,
    input  logic                   head_valid,
    output logic                   pop,
    output logic                   done,
    output logic                   result_status,
    output otbuf_pkg::record_t     rec_out,
    output logic [$clog2(RING_DEPTH+1)-1:0] count_out,
    output logic [31:0]            ovw_out
);

    localparam int PW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);

    otbuf_pkg::record_t mem [RING_DEPTH];
    otbuf_pkg::record_t rd_q;

    logic [PW-1:0] addr;
    logic          done_reg;
    logic          bad_reg;
    logic          show_reg;
    logic [CW-1:0] count_reg;
    logic [31:0]   ovw_reg;

    // Results cannot be held off, so drain the queue every cycle.
    assign pop  = head_valid;
    assign addr = head.addr[PW-1:0];

    always_ff @(posedge clk)
    begin
        if (head_valid && head.op == otbuf_pkg::CMD_WRITE)
        begin
            mem[addr] <= head.rec;
        end
        rd_q <= mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 1'b0;
            bad_reg   <= 1'b0;
            show_reg  <= 1'b0;
            count_reg <= '0;
            ovw_reg   <= '0;
        end
        else
        begin
            done_reg <= head_valid;
            if (head_valid)
            begin
                bad_reg   <= (head.op == otbuf_pkg::CMD_READ) && head.bad;
                show_reg  <= (head.op == otbuf_pkg::CMD_READ) && !head.bad;
                count_reg <= head.count[CW-1:0];
                ovw_reg   <= head.ovw;
            end
        end
    end

    assign done          = done_reg;
    assign result_status = bad_reg;
    assign rec_out       = show_reg ? rd_q : '0;
    assign count_out     = count_reg;
    assign ovw_out       = ovw_reg;

`ifndef SYNTH
    a_done_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> done)
        else $error("popped command produced no result");
`endif

endmodule

// ===== rtl/overwriting_event_trace_buffer.sv =====
// Top level of the overwriting event trace buffer.
// Usage:
//   A request is taken at a rising edge with start high and busy low. action
//   selects log (0), read the Nth newest record (1) or clear and log a boot
//   record (2); code 3 only reports the counters.
//   Each request gives one result: done is high for exactly one cycle with
//   result_status, the record fields (zero unless a valid read), stored_count
//   and overwrite_total. The receiver must take it in that cycle.
//   An accepted request is stored in the command queue; the back end then
//   registers its result and raises done.
//   Throughput: one request per cycle; the record memory serves one write or
//   one read per cycle and the back end drains the command queue each cycle,
//   so busy stays low.
//   boot_code is written through boot_code_we/boot_code_wdata; the user must do so only while idle (not enforced).
//   Reset clears position, count, overwrite counter, boot code and the queue;
//   record memory is not cleared and unwritten entries are never returned.
module overwriting_event_trace_buffer #(
    parameter int RING_DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       action,
    input  logic [31:0]                      time_ms,
    input  logic [15:0]                      event_code,
    input  logic [15:0]                      event_source,
    input  logic signed [31:0]               event_status,
    input  logic [31:0]                      first_arg,
    input  logic [31:0]                      second_arg,
    input  logic [7:0]                       age_index,
    input  logic                             boot_code_we,
    input  logic [15:0]                      boot_code_wdata,
    output logic                             done,
    output logic                             result_status,
    output logic [31:0]                      out_time_ms,
    output logic [15:0]                      out_code,
    output logic [15:0]                      out_source,
    output logic signed [31:0]               out_status,
    output logic [31:0]                      out_first_arg,
    output logic [31:0]                      out_second_arg,
    output logic [$clog2(RING_DEPTH+1)-1:0]  stored_count,
    output logic [31:0]                      overwrite_total
);

    logic [15:0]        boot_code_reg;
    logic               accept;
    otbuf_pkg::record_t rec_in;
    otbuf_pkg::record_t rec_out;
    otbuf_pkg::cmd_t    cmd;
    otbuf_pkg::cmd_t    head;
    logic               q_full;
    logic               q_empty;
    logic               pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boot_code_reg <= '0;
        end
        else if (boot_code_we)
        begin
            boot_code_reg <= boot_code_wdata;
        end
    end

    assign busy   = q_full;
    assign accept = start && !q_full;

    assign rec_in.time_ms    = time_ms;
    assign rec_in.code       = event_code;
    assign rec_in.source     = event_source;
    assign rec_in.status     = event_status;
    assign rec_in.first_arg  = first_arg;
    assign rec_in.second_arg = second_arg;

    otbuf_front #(.RING_DEPTH(RING_DEPTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .action    (action),
        .rec_in    (rec_in),
        .age_index (age_index),
        .boot_code (boot_code_reg),
        .cmd       (cmd)
    );

    otbuf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .push_cmd (cmd),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    otbuf_back #(.RING_DEPTH(RING_DEPTH)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .head_valid    (!q_empty),
        .pop           (pop),
        .done          (done),
        .result_status (result_status),
        .rec_out       (rec_out),
        .count_out     (stored_count),
        .ovw_out       (overwrite_total)
    );

    assign out_time_ms    = rec_out.time_ms;
    assign out_code       = rec_out.code;
    assign out_source     = rec_out.source;
    assign out_status     = rec_out.status;
    assign out_first_arg  = rec_out.first_arg;
    assign out_second_arg = rec_out.second_arg;

endmodule
